// ===== rtl/sha1_pkg.sv =====
// Shared types and constants for the SHA-1 stream hasher.
// Used by every module of the block; depends on nothing else.
package sha1_pkg;

   // One input item: a message byte, its valid flag and the end-of-message mark.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_message;
   } sha1_req_type;

   // One result item: a digest word with its position.
   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } sha1_rsp_type;

   // One 32-bit schedule word on its way from the front end to the round engine.
   // blk_last marks the closing word of the final block of a message.
   typedef struct packed {
      logic [31:0] word;
      logic        blk_last;
   } sha1_word_type;

   localparam int DIGEST_WORDS    = 5;
   localparam int BLOCK_WORDS     = 16;
   localparam int LEN_OFFSET      = 56;
   localparam int LEN_WORD_IDX    = LEN_OFFSET / 4;
   localparam int ROUNDS          = 80;
   localparam int ROUNDS_PER_STEP = 20;

   localparam logic [7:0] PAD_MARKER = 8'h80;

   localparam logic [31:0] INIT_H [DIGEST_WORDS] = '{
      32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
   };

   localparam logic [31:0] K0 = 32'h5A82_7999;
   localparam logic [31:0] K1 = 32'h6ED9_EBA1;
   localparam logic [31:0] K2 = 32'h8F1B_BCDC;
   localparam logic [31:0] K3 = 32'hCA62_C1D6;

endpackage

// ===== rtl/sha1_stream_hasher_unit.sv =====
// SHA-1 stream hasher: bytes in, five big-endian digest words out per message.
// Throughput: one byte per cycle while the word queue has room and no padding is under way;
// each 64-byte block takes 80 rounds and one chaining update in the round engine.
// After the last item the front end writes the padding words; each padded block then goes
// through the round engine, and the digest enters the output register at the final update.
// Reset is synchronous and active high; it empties the queue and restores the initial chain.
module sha1_stream_hasher_unit #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sha1_pkg::sha1_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sha1_pkg::sha1_rsp_type rsp_data
);

   // The front end takes one item per transfer, packs four bytes into a word and, after the
   // end-of-message mark, writes the marker word, zero words and the two length words. It
   // holds req_stall high while it pads and whenever the queue is full.
   //
   // The queue lets the front end gather the next block while the round engine is still
   // busy, so the two sides stall independently of one another.
   //
   // The round engine consumes one word per round during the first sixteen rounds and
   // expands the schedule from a sixteen-word window afterwards. The closing word of a
   // message carries a flag; after that block the digest is moved to an output register
   // of five words, which drains at the pace of rsp_stall while hashing carries on.

   logic                    push_valid;
   sha1_pkg::sha1_word_type push_data;
   logic                    queue_full;
   logic                    pop;
   logic                    head_valid;
   sha1_pkg::sha1_word_type head_data;

   sha1_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   sha1_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   sha1_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== rtl/sha1_front.sv =====
// Front end of the SHA-1 hasher: packs bytes into big-endian words and appends padding.
// Depends on sha1_pkg; feeds sha1_queue.
module sha1_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sha1_pkg::sha1_req_type req_data,
   output logic                   push_valid,
   output sha1_pkg::sha1_word_type push_data,
   input  logic                   queue_full
);

   typedef enum logic [4:0] {
      FS_ACCEPT = 5'b00001,
      FS_MARK   = 5'b00010,
      FS_ZERO   = 5'b00100,
      FS_LEN_HI = 5'b01000,
      FS_LEN_LO = 5'b10000
   } front_state_type;

   front_state_type state_ff, state_in;
   logic [1:0]  pos_ff, pos_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [60:0] len_ff, len_in;
   logic [31:0] word_ff, word_in;
   logic [31:0] pad_word;
   logic        accept;

   assign req_stall = (state_ff != FS_ACCEPT) || queue_full;
   assign accept    = req_valid && !req_stall;

   // Word holding the bytes so far with the marker byte right after them.
   always_comb begin
      case (pos_ff)
         2'd0: pad_word = {sha1_pkg::PAD_MARKER, 24'h0};
         2'd1: pad_word = {word_ff[31:24], sha1_pkg::PAD_MARKER, 16'h0};
         2'd2: pad_word = {word_ff[31:16], sha1_pkg::PAD_MARKER, 8'h0};
         2'd3: pad_word = {word_ff[31:8], sha1_pkg::PAD_MARKER};
         default: pad_word = {sha1_pkg::PAD_MARKER, 24'h0};
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      cnt_in     = cnt_ff;
      len_in     = len_ff;
      word_in    = word_ff;
      push_valid = 1'b0;
      push_data  = '{word: 32'h0, blk_last: 1'b0};
      case (state_ff)
         FS_ACCEPT: begin
            if (accept) begin
               if (req_data.byte_valid) begin
                  len_in = len_ff + 61'd1;
                  pos_in = pos_ff + 2'd1;
                  case (pos_ff)
                     2'd0: word_in = {req_data.data_byte, 24'h0};
                     2'd1: word_in = {word_ff[31:24], req_data.data_byte, 16'h0};
                     2'd2: word_in = {word_ff[31:16], req_data.data_byte, 8'h0};
                     2'd3: word_in = {word_ff[31:8], req_data.data_byte};
                     default: word_in = word_ff;
                  endcase
                  if (pos_ff == 2'd3) begin
                     push_valid = 1'b1;
                     push_data  = '{word: word_in, blk_last: 1'b0};
                     cnt_in     = cnt_ff + 4'd1;
                  end
               end
               if (req_data.end_of_message) begin
                  state_in = FS_MARK;
               end
            end
         end
         FS_MARK, FS_ZERO: begin
            if (!queue_full) begin
               push_valid = 1'b1;
               push_data  = '{word: (state_ff == FS_MARK) ? pad_word : 32'h0,
                              blk_last: 1'b0};
               cnt_in     = cnt_ff + 4'd1;
               // The length goes into the last two words of a block.
               if (cnt_ff == 4'(sha1_pkg::LEN_WORD_IDX - 1)) begin
                  state_in = FS_LEN_HI;
               end else begin
                  state_in = FS_ZERO;
               end
            end
         end
         FS_LEN_HI: begin
            if (!queue_full) begin
               push_valid = 1'b1;
               push_data  = '{word: len_ff[60:29], blk_last: 1'b0};
               cnt_in     = cnt_ff + 4'd1;
               state_in   = FS_LEN_LO;
            end
         end
         FS_LEN_LO: begin
            if (!queue_full) begin
               push_valid = 1'b1;
               push_data  = '{word: {len_ff[28:0], 3'b000}, blk_last: 1'b1};
               cnt_in     = 4'd0;
               pos_in     = 2'd0;
               len_in     = 61'd0;
               state_in   = FS_ACCEPT;
            end
         end
         default: begin
            state_in = FS_ACCEPT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_ACCEPT;
         pos_ff   <= 2'd0;
         cnt_ff   <= 4'd0;
         len_ff   <= 61'd0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
         len_ff   <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

endmodule

// ===== rtl/sha1_queue.sv =====
// Word queue between the SHA-1 front end and the round engine.
// Depends on sha1_pkg for the entry type.
module sha1_queue #(
   parameter int DEPTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  sha1_pkg::sha1_word_type push_data,
   output logic                    full,
   input  logic                    pop,
   output logic                    head_valid,
   output sha1_pkg::sha1_word_type head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sha1_pkg::sha1_word_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/sha1_back.sv =====
// SHA-1 round engine: one round per cycle unless starved; chaining update, digest output.
// Depends on sha1_pkg; takes words from sha1_queue.
module sha1_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  sha1_pkg::sha1_word_type head_data,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output sha1_pkg::sha1_rsp_type  rsp_data
);

   localparam int NW = sha1_pkg::DIGEST_WORDS;

   typedef enum logic [1:0] {
      BS_ROUND  = 2'b01,
      BS_UPDATE = 2'b10
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [6:0]  round_ff, round_in;
   logic        blk_last_ff, blk_last_in;
   logic [31:0] h_ff [NW];
   logic [31:0] h_in [NW];
   logic [31:0] v_ff [NW];
   logic [31:0] v_in [NW];
   logic [31:0] sum  [NW];
   logic [31:0] win_ff [sha1_pkg::BLOCK_WORDS];
   logic [31:0] win_in [sha1_pkg::BLOCK_WORDS];
   logic [31:0] dig_ff [NW];
   logic [31:0] dig_in [NW];
   logic        out_valid_ff, out_valid_in;
   logic [2:0]  idx_ff, idx_in;
   logic        step, early, rsp_done;
   logic [31:0] w_exp, w_cur, fn, kc, t;

   assign early    = (round_ff < 7'(sha1_pkg::BLOCK_WORDS));
   assign step     = (state_ff == BS_ROUND) && (!early || head_valid);
   assign pop      = (state_ff == BS_ROUND) && early && head_valid;
   assign rsp_done = out_valid_ff && !rsp_stall;

   // Message schedule from the sliding window: entry 15 is the newest word.
   assign w_exp = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
   assign w_cur = early ? head_data.word : {w_exp[30:0], w_exp[31]};

   always_comb begin
      if (round_ff < 7'(sha1_pkg::ROUNDS_PER_STEP)) begin
         fn = (v_ff[1] & v_ff[2]) | (~v_ff[1] & v_ff[3]);
         kc = sha1_pkg::K0;
      end else if (round_ff < 7'(2 * sha1_pkg::ROUNDS_PER_STEP)) begin
         fn = v_ff[1] ^ v_ff[2] ^ v_ff[3];
         kc = sha1_pkg::K1;
      end else if (round_ff < 7'(3 * sha1_pkg::ROUNDS_PER_STEP)) begin
         fn = (v_ff[1] & v_ff[2]) | (v_ff[1] & v_ff[3]) | (v_ff[2] & v_ff[3]);
         kc = sha1_pkg::K2;
      end else begin
         fn = v_ff[1] ^ v_ff[2] ^ v_ff[3];
         kc = sha1_pkg::K3;
      end
   end

   assign t = {v_ff[0][26:0], v_ff[0][31:27]} + fn + v_ff[4] + kc + w_cur;

   always_comb begin
      for (int i = 0; i < NW; i++) begin
         sum[i] = h_ff[i] + v_ff[i];
      end
   end

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      blk_last_in  = blk_last_ff;
      h_in         = h_ff;
      v_in         = v_ff;
      win_in       = win_ff;
      dig_in       = dig_ff;
      out_valid_in = out_valid_ff;
      idx_in       = idx_ff;

      if (rsp_done) begin
         for (int i = 0; i < NW - 1; i++) begin
            dig_in[i] = dig_ff[i + 1];
         end
         idx_in = idx_ff + 3'd1;
         if (idx_ff == 3'(NW - 1)) begin
            out_valid_in = 1'b0;
         end
      end

      case (state_ff)
         BS_ROUND: begin
            if (step) begin
               for (int i = 0; i < sha1_pkg::BLOCK_WORDS - 1; i++) begin
                  win_in[i] = win_ff[i + 1];
               end
               win_in[sha1_pkg::BLOCK_WORDS - 1] = w_cur;
               v_in[0] = t;
               v_in[1] = v_ff[0];
               v_in[2] = {v_ff[1][1:0], v_ff[1][31:2]};
               v_in[3] = v_ff[2];
               v_in[4] = v_ff[3];
               if (round_ff == 7'(sha1_pkg::BLOCK_WORDS - 1)) begin
                  blk_last_in = head_data.blk_last;
               end
               if (round_ff == 7'(sha1_pkg::ROUNDS - 1)) begin
                  round_in = 7'd0;
                  state_in = BS_UPDATE;
               end else begin
                  round_in = round_ff + 7'd1;
               end
            end
         end
         BS_UPDATE: begin
            if (!blk_last_ff) begin
               h_in     = sum;
               v_in     = sum;
               state_in = BS_ROUND;
            end else if (!out_valid_ff) begin
               // Digest goes to the output register; chain restarts for the next message.
               dig_in       = sum;
               out_valid_in = 1'b1;
               idx_in       = 3'd0;
               h_in         = sha1_pkg::INIT_H;
               v_in         = sha1_pkg::INIT_H;
               state_in     = BS_ROUND;
            end
         end
         default: begin
            state_in = BS_ROUND;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_ROUND;
         round_ff     <= 7'd0;
         blk_last_ff  <= 1'b0;
         h_ff         <= sha1_pkg::INIT_H;
         v_ff         <= sha1_pkg::INIT_H;
         out_valid_ff <= 1'b0;
         idx_ff       <= 3'd0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         blk_last_ff  <= blk_last_in;
         h_ff         <= h_in;
         v_ff         <= v_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      dig_ff <= dig_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = '{digest_word: dig_ff[0], word_index: idx_ff,
                        last_word: (idx_ff == 3'(NW - 1))};

endmodule

// ===== rtl/sha1_checker.sv =====
// Port-level checks for the SHA-1 stream hasher, bound to the top level.
// Depends on sha1_pkg for the port types.
module sha1_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input sha1_pkg::sha1_rsp_type rsp_data
);

   // A stalled result must still be offered unchanged in the next cycle.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.word_index <= 3'd4)
      else $error("digest word index out of range");

   a_last_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_word == (rsp_data.word_index == 3'd4)))
      else $error("last word mark does not match index");

   // The five digest words leave back to back: after one transfer the next word is ready.
   a_word_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_word |=>
         rsp_valid && (rsp_data.word_index == $past(rsp_data.word_index) + 3'd1))
      else $error("digest word sequence broken");

endmodule

bind sha1_stream_hasher_unit sha1_checker u_sha1_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for sha1_stream_hasher_unit: byte streams in, digest words out.
// Holds its own SHA-1 model in a small scoreboard class; depends only on sha1_pkg and the unit.
module testbench;

   // The scoreboard keeps its own copy of the hashing state. Every accepted input transfer is
   // folded into that state, and a message end queues the five digest words it must produce.
   class digest_scoreboard;
      logic [31:0]            chain_h [5];
      logic [7:0]             blk_bytes [64];
      int                     fill_bytes;
      logic [60:0]            msg_len;
      sha1_pkg::sha1_rsp_type expected_words [$];
      int                     mismatches;

      function new();
         restart_message();
         mismatches = 0;
      endfunction

      function void restart_message();
         chain_h[0] = 32'h6745_2301;
         chain_h[1] = 32'hEFCD_AB89;
         chain_h[2] = 32'h98BA_DCFE;
         chain_h[3] = 32'h1032_5476;
         chain_h[4] = 32'hC3D2_E1F0;
         fill_bytes = 0;
         msg_len = '0;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      // One 80-round compression of blk_bytes into chain_h.
      function void compress_block();
         logic [31:0] w [80];
         logic [31:0] a, b, c, d, e, f, k, t, x;
         for (int r = 0; r < 16; r++)
            w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
         for (int r = 16; r < 80; r++) begin
            x = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
            w[r] = {x[30:0], x[31]};
         end
         a = chain_h[0];
         b = chain_h[1];
         c = chain_h[2];
         d = chain_h[3];
         e = chain_h[4];
         for (int r = 0; r < 80; r++) begin
            if (r < 20) begin
               f = (b & c) | (~b & d);
               k = 32'h5A82_7999;
            end else if (r < 40) begin
               f = b ^ c ^ d;
               k = 32'h6ED9_EBA1;
            end else if (r < 60) begin
               f = (b & c) | (b & d) | (c & d);
               k = 32'h8F1B_BCDC;
            end else begin
               f = b ^ c ^ d;
               k = 32'hCA62_C1D6;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[r];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
         end
         chain_h[0] += a;
         chain_h[1] += b;
         chain_h[2] += c;
         chain_h[3] += d;
         chain_h[4] += e;
      endfunction

      // Fold one accepted input transfer into the model.
      function void absorb_item(sha1_pkg::sha1_req_type it);
         logic [63:0]            bit_len;
         sha1_pkg::sha1_rsp_type word;
         if (it.byte_valid) begin
            blk_bytes[fill_bytes] = it.data_byte;
            fill_bytes++;
            msg_len++;
            if (fill_bytes == 64) begin
               compress_block();
               fill_bytes = 0;
            end
         end
         if (!it.end_of_message)
            return;
         bit_len = {msg_len, 3'b000};
         blk_bytes[fill_bytes] = 8'h80;
         fill_bytes++;
         // No room left for the length field, so it goes into an extra block.
         if (fill_bytes > 56) begin
            for (int i = fill_bytes; i < 64; i++)
               blk_bytes[i] = 8'h00;
            compress_block();
            fill_bytes = 0;
         end
         for (int i = fill_bytes; i < 56; i++)
            blk_bytes[i] = 8'h00;
         for (int i = 0; i < 8; i++)
            blk_bytes[56+i] = bit_len[8*(7-i) +: 8];
         compress_block();
         for (int i = 0; i < 5; i++) begin
            word.digest_word = chain_h[i];
            word.word_index  = 3'(i);
            word.last_word   = (i == 4);
            expected_words.push_back(word);
         end
         restart_message();
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch in %s: got %h, expected %h", what, got, want);
         mismatches++;
      endtask

      // Compare one accepted result transfer with the oldest digest word still owed.
      task check_digest_word(sha1_pkg::sha1_rsp_type got);
         sha1_pkg::sha1_rsp_type want;
         if (expected_words.size() == 0) begin
            report("digest word with none outstanding", got.digest_word, 32'h0);
            return;
         end
         want = expected_words.pop_front();
         if (got.digest_word !== want.digest_word)
            report("digest_word", got.digest_word, want.digest_word);
         if (got.word_index !== want.word_index)
            report("word_index", 32'(got.word_index), 32'(want.word_index));
         if (got.last_word !== want.last_word)
            report("last_word", 32'(got.last_word), 32'(want.last_word));
      endtask
   endclass

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   sha1_pkg::sha1_req_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   sha1_pkg::sha1_rsp_type rsp_data;

   digest_scoreboard sb;

   // While set, the sender presents items back to back with no idle cycles.
   bit sender_steady = 1'b0;

   sha1_stream_hasher_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Both monitors sample at the rising edge, before any of that edge's updates have landed,
   // so they see exactly the values on which the handshake was decided. Results are checked
   // before the new input is absorbed; with the block's long latency the order is immaterial.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_digest_word(rsp_data);
         if (req_valid && !req_stall)
            sb.absorb_item(req_data);
      end
   end

   // The result side alternates between ready and stalled runs. Most runs are short, but now and
   // then a long stall holds the block back, and a long ready run gives stretches with no stall.
   initial begin : rsp_stall_gen
      int run;
      forever begin
         rsp_stall <= 1'b0;
         run = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 10);
         repeat (run) @(posedge clock);
         rsp_stall <= 1'b1;
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
         repeat (run) @(posedge clock);
      end
   end

   // Idle cycles before the next input transfer: mostly none or a few, occasionally a long gap.
   function automatic int pick_gap();
      int roll;
      if (sender_steady)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Present one item and hold it until the transfer takes place. The task is entered and left
   // just after a rising edge, so valid is written at most once in any time step.
   task automatic send_item(input logic [7:0] data, input logic valid, input logic eom);
      sha1_pkg::sha1_req_type it;
      int                     gap;
      it.data_byte      = data;
      it.byte_valid     = valid;
      it.end_of_message = eom;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
   endtask

   // Send a message of random bytes. The end mark rides either on the final byte or on a
   // separate item without a byte; an empty message always takes the latter form. Now and then
   // an idle item (no byte, no end mark) is slipped in, which the block must ignore.
   task automatic send_message(input int len, input bit mark_on_byte, output int items);
      items = 0;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_item(8'($urandom), 1'b0, 1'b0);
            items++;
         end
         send_item(8'($urandom), 1'b1, (mark_on_byte && i == len - 1));
         items++;
      end
      if (!mark_on_byte || len == 0) begin
         send_item(8'($urandom), 1'b0, 1'b1);
         items++;
      end
   endtask

   // Main sequence: reset, a short directed part, then random messages.
   initial begin : stimulus
      int boundary_lens [];
      int total_items;
      int len;
      int n;
      boundary_lens = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
      sb = new();
      total_items = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. The empty message comes first, straight after reset, and again twice
      // back to back. Idle items carrying 0xFF and 0x00 must leave no trace.
      send_item(8'hFF, 1'b0, 1'b1);
      send_item(8'hFF, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      // A single byte with the end mark on it, at both extremes of the byte range.
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hFF, 1'b1, 1'b1);
      // A single byte followed by a separate end item whose byte field must be ignored.
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'hA5, 1'b0, 1'b1);
      // The classic three-letter message, with an idle item in the middle.
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h3C, 1'b0, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'h00, 1'b0, 1'b1);
      total_items = 13;

      // Random part. Half of the messages are short; the rest sit on or near the lengths where
      // the padding needs an extra block or a block fills exactly, or are of random middle size.
      while (total_items < 320) begin
         sender_steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 1) == 0)
            len = $urandom_range(0, 20);
         else if ($urandom_range(0, 3) != 0)
            len = boundary_lens[$urandom_range(0, boundary_lens.size() - 1)];
         else
            len = $urandom_range(21, 130);
         send_message(len, $urandom_range(0, 1), n);
         total_items += n;
      end
      req_valid <= 1'b0;
      sender_steady = 1'b0;

      // Drain: wait for every owed digest word, then idle a little longer than the worst
      // latency so that any spurious extra word would still be caught.
      while (sb.pending() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (sb.mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run of this stimulus.
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/sha1_pkg.sv
rtl/sha1_front.sv
rtl/sha1_queue.sv
rtl/sha1_back.sv
rtl/sha1_stream_hasher_unit.sv
rtl/sha1_checker.sv
tb/testbench.sv
